@@ design/apt_pkg.sv @@
// Shared request codes, field widths and matrix dimensions for the affine point transform.
package apt_pkg;

  localparam int TYPE_W = 2;
  localparam int IDX_W  = 2;

  localparam int NUM_ROWS  = 4;
  localparam int NUM_COLS  = 3;
  localparam int NUM_AXES  = 3;

  localparam logic [TYPE_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_VECTOR = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_POINT  = 2'd2;

  localparam logic [IDX_W-1:0] ROW_TRANS = 2'd3;
  localparam logic [IDX_W-1:0] COL_LIMIT = 2'd3;

endpackage

@@ design/apt_req_if.sv @@
// Request channel: coefficient loads and vector or point transforms.
interface apt_req_if import apt_pkg::*; #(
  parameter int COORD_WIDTH = 32
) ();

  logic                          valid;
  logic                          ready;
  logic [TYPE_W-1:0]             req_type;
  logic [IDX_W-1:0]              coeff_row;
  logic [IDX_W-1:0]              coeff_col;
  logic signed [COORD_WIDTH-1:0] coeff_value;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;

  modport source (
    output valid, req_type, coeff_row, coeff_col, coeff_value, in_x, in_y, in_z,
    input  ready
  );

  modport sink (
    input  valid, req_type, coeff_row, coeff_col, coeff_value, in_x, in_y, in_z,
    output ready
  );

endinterface

@@ design/apt_res_if.sv @@
// Result channel: transformed coordinates and the saturation flag.
interface apt_res_if #(
  parameter int COORD_WIDTH = 32
) ();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          clipped;

  modport source (
    output valid, out_x, out_y, out_z, clipped,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, clipped,
    output ready
  );

endinterface

@@ design/apt_sat_sum.sv @@
// One output column: add three scaled products and optional translation, then saturate.
module apt_sat_sum import apt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic signed [2*COORD_WIDTH-FRAC_BITS-1:0] prod0,
  input  logic signed [2*COORD_WIDTH-FRAC_BITS-1:0] prod1,
  input  logic signed [2*COORD_WIDTH-FRAC_BITS-1:0] prod2,
  input  logic signed [COORD_WIDTH-1:0]             trans,
  input  logic                                      add_trans,
  output logic signed [COORD_WIDTH-1:0]             sum,
  output logic                                      clip
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * COORD_WIDTH - FRAC_BITS;
  localparam int SW = PW + 2;

  localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

  logic signed [SW-1:0] total;
  logic signed [SW-1:0] trans_ext;
  logic [SW-W:0]        upper;

  always_comb begin
    trans_ext = add_trans ? SW'(trans) : '0;
    total     = SW'(prod0) + SW'(prod1) + SW'(prod2) + trans_ext;
    upper     = total[SW-1:W-1];
    // in range only when every bit above the result's sign agrees with it
    clip      = !((&upper) || !(|upper));
    if (clip) begin
      sum = total[SW-1] ? MIN_VAL : MAX_VAL;
    end else begin
      sum = total[W-1:0];
    end
  end

endmodule

@@ design/affine_point_transform.sv @@
// Top level: 3-D affine transform of vectors and points by a stored 4x3 coefficient matrix.
// An accepted transform word passes the input, product and result registers to the result channel.
// Throughput: one request word per cycle while the result channel does not stall; loads retire without a result.
// The pipe has three stages: input register, product register, result register.
// Reset clears all valid flags and loads the identity matrix with a zero translation row.
module affine_point_transform import apt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst,
  apt_req_if.sink   req,
  apt_res_if.source res
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * COORD_WIDTH - FRAC_BITS;

  localparam logic signed [W-1:0] ONE_VAL = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Coefficient store: rows 0..2 are the linear part, row 3 the translation.
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] coeff [NUM_ROWS][NUM_COLS];

  // ---------------------------------------------------------------------------
  // Stage 1: input register. Loads are applied here and retire without waiting for downstream room.
  // ---------------------------------------------------------------------------
  logic                s1_valid;
  logic [TYPE_W-1:0]   s1_type;
  logic [IDX_W-1:0]    s1_row;
  logic [IDX_W-1:0]    s1_col;
  logic signed [W-1:0] s1_value;
  logic signed [W-1:0] s1_vec [NUM_AXES];

  // Stage 2: scaled products plus the translation row captured with them.
  logic                 s2_valid;
  logic                 s2_point;
  logic signed [PW-1:0] s2_prod [NUM_AXES][NUM_COLS];
  logic signed [W-1:0]  s2_trans [NUM_COLS];

  // Stage 3: result register driving the output channel.
  logic                s3_valid;
  logic signed [W-1:0] s3_out [NUM_COLS];
  logic                s3_clip;

  logic s1_xform;
  logic s1_adv;
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic load_write;

  logic signed [2*W-1:0] full_prod [NUM_AXES][NUM_COLS];
  logic signed [W-1:0]   col_sum [NUM_COLS];
  logic [NUM_COLS-1:0]   col_clip;

  // Backpressure: each stage moves when the stage ahead has room or is moving on.
  assign s3_ready = !s3_valid || res.ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_xform = s1_type inside {REQ_VECTOR, REQ_POINT};
  // loads and unused request codes never wait for downstream room
  assign s1_adv   = s1_valid && (!s1_xform || s2_ready);
  assign s1_ready = !s1_valid || s1_adv;
  assign req.ready = s1_ready;

  // Drop loads aimed at the unused fourth column.
  assign load_write = s1_valid && (s1_type == REQ_LOAD) && (s1_col < COL_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= req.valid;
    end
    if (s1_ready && req.valid) begin
      s1_type     <= req.req_type;
      s1_row      <= req.coeff_row;
      s1_col      <= req.coeff_col;
      s1_value    <= req.coeff_value;
      s1_vec[0]   <= req.in_x;
      s1_vec[1]   <= req.in_y;
      s1_vec[2]   <= req.in_z;
    end
  end

  // Write the store as the load leaves stage 1, so a transform right behind it
  // sees the new value on its own stage-1 cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          coeff[r][c] <= (r == c) ? ONE_VAL : '0;
        end
      end
    end else if (load_write) begin
      coeff[s1_row][s1_col] <= s1_value;
    end
  end

  // Full-precision products; keep the bits above the fraction (floor shift).
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        full_prod[r][c] = s1_vec[r] * coeff[r][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid && s1_xform;
    end
    if (s2_ready && s1_valid && s1_xform) begin
      s2_point <= (s1_type == REQ_POINT);
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          s2_prod[r][c] <= full_prod[r][c][2*W-1:FRAC_BITS];
        end
      end
      for (int c = 0; c < NUM_COLS; c++) begin
        s2_trans[c] <= coeff[ROW_TRANS][c];
      end
    end
  end

  // Column sums with saturation, one adder tree per output coordinate.
  for (genvar j = 0; j < NUM_COLS; j++) begin : g_col
    apt_sat_sum #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_sum (
      .prod0     (s2_prod[0][j]),
      .prod1     (s2_prod[1][j]),
      .prod2     (s2_prod[2][j]),
      .trans     (s2_trans[j]),
      .add_trans (s2_point),
      .sum       (col_sum[j]),
      .clip      (col_clip[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
    if (s3_ready && s2_valid) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        s3_out[c] <= col_sum[c];
      end
      s3_clip <= |col_clip;
    end
  end

  assign res.valid   = s3_valid;
  assign res.out_x   = s3_out[0];
  assign res.out_y   = s3_out[1];
  assign res.out_z   = s3_out[2];
  assign res.clipped = s3_clip;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // A saturated word must carry at least one coordinate pinned at a limit.
  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.clipped) |->
      (res.out_x == MAX_VAL || res.out_x == MIN_VAL ||
       res.out_y == MAX_VAL || res.out_y == MIN_VAL ||
       res.out_z == MAX_VAL || res.out_z == MIN_VAL))
    else $error("clipped flag without a saturated coordinate");

  // Loads and unused codes retire from the input register without waiting.
  a_load_no_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_xform) |-> s1_adv)
    else $error("non-transform word held in input register");

  // Reset leaves the identity matrix in place.
  a_reset_identity: assert property (@(posedge clk)
    $past(rst) |-> (coeff[0][0] == ONE_VAL && coeff[1][1] == ONE_VAL &&
                    coeff[2][2] == ONE_VAL && coeff[0][1] == '0 &&
                    coeff[ROW_TRANS][0] == '0))
    else $error("coefficient store not identity after reset");

  // A word only enters the product stage from a transform request.
  a_prod_from_xform: assert property (@(posedge clk) disable iff (rst)
    ($past(s2_ready) && s2_valid) |-> ($past(s1_valid) && $past(s1_xform)))
    else $error("product stage loaded without a transform request");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the affine point transform: directed table, random words, stalls.
module testbench;
  import apt_pkg::*;

  localparam int CW         = 32;
  localparam int FRAC       = 16;
  localparam int ACC_W      = 80;
  localparam int CLK_PERIOD = 8;
  localparam int SETTLE     = 8;        // settle time after the last expected result
  localparam int HOLD_LEN   = 60;       // long receiver hold-off under pressure
  localparam int PHASE_LEN  = 200;
  localparam int MAX_CYCLES = 200_000;

  // Type code with no meaning; the block drops such words.
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

  typedef logic signed [CW-1:0] coord_t;

  localparam logic signed [ACC_W-1:0] SAT_HI = 80'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_LO = -80'sd2147483648;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    coord_t            coeff;
    coord_t            x;
    coord_t            y;
    coord_t            z;
  } req_word_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   clipped;
  } coord_res_t;

  // One row of the directed table; pinned rows carry a result typed in by hand.
  typedef struct packed {
    req_word_t  w;
    logic       pinned;
    coord_res_t want;
  } stim_row_t;

  localparam coord_t EXTREMES [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

  logic clk = 1'b0;
  logic rst;

  apt_req_if #(.COORD_WIDTH(CW)) req_ch ();
  apt_res_if #(.COORD_WIDTH(CW)) res_ch ();

  affine_point_transform #(
    .COORD_WIDTH (CW),
    .FRAC_BITS   (FRAC)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: our own copy of the coefficient matrix.
  coord_t     coef_mat [NUM_ROWS][NUM_COLS];
  coord_res_t pending_coords [$];

  // Hand-typed expectation for the word currently offered, if any.
  logic       pin_valid = 1'b0;
  coord_res_t pin_res;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_req      = 1'b0;
  int unsigned hold_left     = 0;

  int unsigned mismatches = 0;
  int unsigned n_load     = 0;
  int unsigned n_vector   = 0;
  int unsigned n_point    = 0;
  int unsigned n_ignored  = 0;
  int unsigned n_results  = 0;
  int unsigned n_clipped  = 0;

  coord_res_t predicted;
  coord_res_t want_now;
  stim_row_t  directed [$];

  // Work out one transform: exact products, floor to Q16.16, exact sum, then saturate.
  function automatic coord_res_t transform_coords(input logic [TYPE_W-1:0] kind,
                                                  input coord_t x, input coord_t y,
                                                  input coord_t z);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] term;
    coord_t                  v [NUM_AXES];
    coord_t                  o [NUM_AXES];
    logic                    clip;
    coord_res_t              r;
    int                      j;
    int                      k;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    clip = 1'b0;
    for (j = 0; j < NUM_AXES; j++) begin
      acc = '0;
      for (k = 0; k < NUM_AXES; k++) begin
        term = $signed({{(ACC_W-CW){v[k][CW-1]}}, v[k]})
             * $signed({{(ACC_W-CW){coef_mat[k][j][CW-1]}}, coef_mat[k][j]});
        acc  = acc + (term >>> FRAC);
      end
      if (kind == REQ_POINT)
        acc = acc + $signed({{(ACC_W-CW){coef_mat[ROW_TRANS][j][CW-1]}},
                             coef_mat[ROW_TRANS][j]});
      if (acc > SAT_HI) begin
        o[j] = 32'h7FFF_FFFF;
        clip = 1'b1;
      end else if (acc < SAT_LO) begin
        o[j] = 32'h8000_0000;
        clip = 1'b1;
      end else begin
        o[j] = acc[CW-1:0];
      end
    end
    r.x       = o[0];
    r.y       = o[1];
    r.z       = o[2];
    r.clipped = clip;
    return r;
  endfunction

  function automatic stim_row_t row_of(input logic [TYPE_W-1:0] kind,
                                       input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                                       input coord_t coeff, input coord_t x, input coord_t y,
                                       input coord_t z);
    stim_row_t s;
    s.w      = '{kind: kind, row: row, col: col, coeff: coeff, x: x, y: y, z: z};
    s.pinned = 1'b0;
    s.want   = '0;
    return s;
  endfunction

  function automatic stim_row_t pin_row(input logic [TYPE_W-1:0] kind,
                                        input coord_t x, input coord_t y, input coord_t z,
                                        input coord_t wx, input coord_t wy, input coord_t wz,
                                        input logic wclip);
    stim_row_t s;
    s.w      = '{kind: kind, row: '0, col: '0, coeff: '0, x: x, y: y, z: z};
    s.pinned = 1'b1;
    s.want   = '{x: wx, y: wy, z: wz, clipped: wclip};
    return s;
  endfunction

  // Coordinates: mostly moderate magnitudes, with full-range values and extremes mixed in.
  function automatic coord_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0)
      return EXTREMES[$urandom_range(3)];
    if (pick < 4)
      return coord_t'($urandom);
    return coord_t'($urandom_range(8388607)) - 32'sd4194304;
  endfunction

  // Coefficients: mostly within plus or minus two, so that results do not always clip.
  function automatic coord_t rand_coeff();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0)
      return EXTREMES[$urandom_range(3)];
    if (pick < 3)
      return coord_t'($urandom);
    return coord_t'($urandom_range(262143)) - 32'sd131072;
  endfunction

  // Random word; fields that the chosen type ignores carry junk on purpose.
  function automatic req_word_t rand_word();
    req_word_t   w;
    int unsigned pick;
    w.row   = IDX_W'($urandom);
    w.col   = IDX_W'($urandom);
    w.coeff = coord_t'($urandom);
    w.x     = rand_coord();
    w.y     = rand_coord();
    w.z     = rand_coord();
    pick    = $urandom_range(99);
    if (pick < 22) begin
      w.kind  = REQ_LOAD;
      w.row   = IDX_W'($urandom_range(NUM_ROWS - 1));
      w.col   = ($urandom_range(9) == 0) ? COL_LIMIT : IDX_W'($urandom_range(NUM_COLS - 1));
      w.coeff = rand_coeff();
      w.x     = coord_t'($urandom);
      w.y     = coord_t'($urandom);
      w.z     = coord_t'($urandom);
    end else if (pick < 26) begin
      w.kind = REQ_UNUSED;
    end else begin
      w.kind = $urandom_range(1) ? REQ_POINT : REQ_VECTOR;
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                 input logic [CW-1:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Offer one word from a falling edge; return at the falling edge after it is taken.
  task automatic send_word(input req_word_t w, input logic pinned, input coord_res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pin_valid = pinned;
    pin_res   = want;
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= w.kind;
    req_ch.coeff_row   <= w.row;
    req_ch.coeff_col   <= w.col;
    req_ch.coeff_value <= w.coeff;
    req_ch.in_x        <= w.x;
    req_ch.in_y        <= w.y;
    req_ch.in_z        <= w.z;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Pause the sender until every expected result has come, then let the pipe settle.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    pin_valid = 1'b0;
    while (pending_coords.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Receiver: take a long hold-off when asked, otherwise stall at the phase's rate.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Request monitor: update the matrix copy on loads, queue the expectation on transforms.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      case (req_ch.req_type)
        REQ_LOAD: begin
          n_load++;
          // a load aimed at the unused fourth column leaves the matrix alone
          if (req_ch.coeff_col != COL_LIMIT)
            coef_mat[req_ch.coeff_row][req_ch.coeff_col] = req_ch.coeff_value;
        end
        REQ_VECTOR, REQ_POINT: begin
          if (req_ch.req_type == REQ_POINT)
            n_point++;
          else
            n_vector++;
          predicted = transform_coords(req_ch.req_type, req_ch.in_x, req_ch.in_y, req_ch.in_z);
          pending_coords.push_back(pin_valid ? pin_res : predicted);
        end
        default: n_ignored++;
      endcase
    end
  end

  // Result checker: compare every word taken against the oldest expectation, field by field.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_coords.size() == 0) begin
        report_mismatch("unexpected result word", res_ch.out_x, '0);
      end else begin
        want_now = pending_coords.pop_front();
        n_results++;
        if (res_ch.clipped === 1'b1)
          n_clipped++;
        if (res_ch.out_x !== want_now.x)
          report_mismatch("out_x", res_ch.out_x, want_now.x);
        if (res_ch.out_y !== want_now.y)
          report_mismatch("out_y", res_ch.out_y, want_now.y);
        if (res_ch.out_z !== want_now.z)
          report_mismatch("out_z", res_ch.out_z, want_now.z);
        if (res_ch.clipped !== want_now.clipped)
          report_mismatch("clipped", CW'(res_ch.clipped), CW'(want_now.clipped));
      end
    end
  end

  // Stimulus.
  initial begin
    int unsigned idle_tbl  [4];
    int unsigned stall_tbl [4];
    int          ph;
    int          i;
    int          r;
    int          c;
    req_word_t   w;

    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_LOAD;
    req_ch.coeff_row   = '0;
    req_ch.coeff_col   = '0;
    req_ch.coeff_value = '0;
    req_ch.in_x        = '0;
    req_ch.in_y        = '0;
    req_ch.in_z        = '0;
    pin_res            = '0;

    // the matrix comes out of reset as identity with a zero translation row
    for (r = 0; r < NUM_ROWS; r++)
      for (c = 0; c < NUM_COLS; c++)
        coef_mat[r][c] = (r == c) ? 32'sh0001_0000 : '0;

    // Directed table. Identity first: coordinates pass through unchanged.
    directed.push_back(pin_row(REQ_VECTOR, 32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000,
                               32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000, 1'b0));
    directed.push_back(pin_row(REQ_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                               32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0));
    directed.push_back(pin_row(REQ_VECTOR, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
    // drop a load to column three and a word of the unused type; the matrix must not move
    directed.push_back(row_of(REQ_LOAD, 2'd1, COL_LIMIT, 32'h1234_5678,
                              32'hDEAD_BEEF, 32'h0BAD_F00D, 32'hFFFF_FFFF));
    directed.push_back(row_of(REQ_UNUSED, 2'd2, 2'd1, 32'h7FFF_FFFF,
                              32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
    directed.push_back(pin_row(REQ_VECTOR, 32'h0007_0000, 32'h0008_0000, 32'h0009_0000,
                               32'h0007_0000, 32'h0008_0000, 32'h0009_0000, 1'b0));
    // largest coefficients in column 0: x overflows both ways, y passes through
    directed.push_back(row_of(REQ_LOAD, 2'd0, 2'd0, 32'h7FFF_FFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(row_of(REQ_LOAD, 2'd1, 2'd0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0));
    directed.push_back(pin_row(REQ_VECTOR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b1));
    directed.push_back(pin_row(REQ_VECTOR, 32'h8000_0000, 32'h8000_0000, 32'h0,
                               32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1));
    // most negative coefficient times most negative coordinate
    directed.push_back(row_of(REQ_LOAD, 2'd0, 2'd0, 32'h8000_0000, 32'h0, 32'h0, 32'h0));
    directed.push_back(row_of(REQ_VECTOR, ROW_TRANS, 2'd2, 32'h5555_AAAA,
                              32'h8000_0000, 32'h0000_0001, 32'hFFFF_0000));
    // translation row, then restore the linear part to identity
    directed.push_back(row_of(REQ_LOAD, ROW_TRANS, 2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
    directed.push_back(row_of(REQ_LOAD, ROW_TRANS, 2'd1, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0));
    directed.push_back(row_of(REQ_LOAD, ROW_TRANS, 2'd2, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0));
    directed.push_back(row_of(REQ_LOAD, 2'd0, 2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
    directed.push_back(row_of(REQ_LOAD, 2'd1, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0));
    directed.push_back(pin_row(REQ_POINT, 32'h0, 32'h0, 32'h0,
                               32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b0));
    // z plus the largest translation overflows; a vector ignores the translation
    directed.push_back(pin_row(REQ_POINT, 32'h0, 32'h0, 32'h0001_0000,
                               32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1));
    directed.push_back(pin_row(REQ_VECTOR, 32'h0, 32'h0, 32'h0001_0000,
                               32'h0, 32'h0, 32'h0001_0000, 1'b0));
    // fractional coefficients: products that round down
    directed.push_back(row_of(REQ_LOAD, 2'd2, 2'd1, 32'hFFFF_8000, 32'h0, 32'h0, 32'h0));
    directed.push_back(row_of(REQ_LOAD, 2'd1, 2'd2, 32'h0000_8001, 32'h0, 32'h0, 32'h0));
    directed.push_back(row_of(REQ_POINT, 2'd0, 2'd0, 32'h0,
                              32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0001));
    directed.push_back(row_of(REQ_VECTOR, 2'd3, 2'd3, 32'hFFFF_FFFF,
                              32'h0001_2345, 32'hFFFE_DCBA, 32'hFFFF_FFFF));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, no idling on either side.
    foreach (directed[i])
      send_word(directed[i].w, directed[i].pinned, directed[i].want);
    drain_results();

    // Random phases: no idling, sender idle, receiver stalling, both.
    idle_tbl  = '{0, 46, 0, 32};
    stall_tbl = '{0, 0, 46, 32};
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tbl[ph];
      stall_pct     = stall_tbl[ph];
      repeat (PHASE_LEN) send_word(rand_word(), 1'b0, '0);
      drain_results();
    end

    // Pressure: hold the receiver off while a stream of transforms fills the pipe.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b1;
    for (i = 0; i < 48; i++) begin
      w      = rand_word();
      w.kind = REQ_POINT;
      send_word(w, 1'b0, '0);
    end
    drain_results();

    $display("Covered %0d loads, %0d vector and %0d point transforms, %0d dropped words.",
             n_load, n_vector, n_point, n_ignored);
    $display("Checked %0d result words, %0d of them clipped; %0d mismatches.",
             n_results, n_clipped, mismatches);
    if (mismatches == 0 && pending_coords.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: end the run if results stop coming.
  initial begin
    #(CLK_PERIOD * MAX_CYCLES);
    $display("Timeout with %0d results outstanding.", pending_coords.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
